[design/wsrm_pkg.sv]
`default_nettype none

package wsrm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int STORE_BYTES     = 32;
    localparam int WORD_COUNT      = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int LEN_W           = 6;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd4;

    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_CONSUME = 1'b1;

    typedef struct packed {
        logic whole_match;
        logic still_possible;
    } t_flags;

    // A pattern element hits a text byte when it is a dot or the same byte.
    function automatic logic elem_hits(input logic [7:0] elem, input logic [7:0] c);
        return (elem == DOT_BYTE) || (elem == c);
    endfunction

endpackage

`default_nettype wire

[design/wsrm_req_if.sv]
`default_nettype none

interface wsrm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] text_char;

    modport source (output valid, output req_type, output text_char, input ready);
    modport sink   (input valid, input req_type, input text_char, output ready);
endinterface

`default_nettype wire

[design/wsrm_res_if.sv]
`default_nettype none

interface wsrm_res_if;
    logic valid;
    logic ready;
    logic whole_match;
    logic still_possible;

    modport source (output valid, output whole_match, output still_possible, input ready);
    modport sink   (input valid, input whole_match, input still_possible, output ready);
endinterface

`default_nettype wire

[design/wsrm_cfg.sv]
`default_nettype none

module wsrm_cfg
    import wsrm_pkg::*;
#(
    parameter int LANES = PATTERN_MAX_DEF,
    parameter int NW    = $clog2(LANES + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    output logic      [STORE_BYTES*8-1:0]    o_pattern,
    output logic      [NW-1:0]               o_used_len
);

    logic [CFG_DATA_W-1:0] r_word [WORD_COUNT];
    logic [LEN_W-1:0]      r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORD_COUNT; w++) begin
                r_word[w] <= '0;
            end
            r_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PATTERN_0: r_word[0] <= i_cfg_data;
                REG_PATTERN_1: r_word[1] <= i_cfg_data;
                REG_PATTERN_2: r_word[2] <= i_cfg_data;
                REG_PATTERN_3: r_word[3] <= i_cfg_data;
                REG_LENGTH:    r_len     <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int w = 0; w < WORD_COUNT; w++) begin
            o_pattern[w*CFG_DATA_W +: CFG_DATA_W] = r_word[w];
        end
    end

    // Lengths beyond the lanes that exist are clamped to the last lane.
    assign o_used_len = (r_len > LEN_W'(LANES)) ? NW'(LANES) : r_len[NW-1:0];

endmodule

`default_nettype wire

[design/wsrm_step.sv]
`default_nettype none

module wsrm_step
    import wsrm_pkg::*;
#(
    parameter int LANES = PATTERN_MAX_DEF,
    parameter int NW    = $clog2(LANES + 1)
) (
    input  wire logic [STORE_BYTES*8-1:0] i_pattern,
    input  wire logic [NW-1:0]            i_used_len,
    input  wire logic [LANES:0]           i_row,
    input  wire logic                     i_consume,
    input  wire logic [7:0]               i_char,
    output logic      [LANES:0]           o_row,
    output t_flags                        o_flags
);

    always_comb begin
        logic [7:0] p;
        logic [7:0] elem;
        logic       in_use;
        logic       more;
        o_row    = '0;
        o_row[0] = !i_consume;
        for (int j = 1; j <= LANES; j++) begin
            p      = i_pattern[(j-1)*8 +: 8];
            in_use = (NW'(j) <= i_used_len);
            elem   = '0;
            more   = 1'b0;
            if (p == STAR_BYTE) begin
                // A star either skips its element (two lanes back) or repeats it.
                if (j >= 2) begin
                    elem     = i_pattern[(j-2)*8 +: 8];
                    more     = i_consume && i_row[j] && elem_hits(elem, i_char);
                    o_row[j] = in_use && (o_row[j-2] || more);
                end
            end else begin
                o_row[j] = in_use && i_consume && i_row[j-1] && elem_hits(p, i_char);
            end
        end
    end

    assign o_flags.whole_match    = o_row[i_used_len];
    assign o_flags.still_possible = |o_row;

endmodule

`default_nettype wire

[design/wildcard_star_regex_matcher_top.sv]
// Channel  Direction  Word contents
// req      in         req_type (restart or consume), text_char
// res      out        whole_match, still_possible
// cfg      in         i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// Each word passes through the input register and then the result register;
// one word is accepted per cycle, no bubbles between words, unless the result stalls.
// The rate is set by the row update, one pass from the row register to the
// result register including the star ripple along the pattern lanes.
// Reset clears the pattern, the length and the row, so a restart word is needed first.
// A stalled result holds the input register, which then holds req.ready low.
`default_nettype none

module wildcard_star_regex_matcher_top
    import wsrm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    wsrm_req_if.sink                   req,
    wsrm_res_if.source                 res
);

    localparam int LANES = (PATTERN_MAX < STORE_BYTES) ? PATTERN_MAX : STORE_BYTES;
    localparam int NW    = $clog2(LANES + 1);

    logic [STORE_BYTES*8-1:0] pattern;
    logic [NW-1:0]            used_len;
    logic [LANES:0]           n_row;
    t_flags                   n_flags;

    logic                     r_in_valid;
    logic                     r_in_type;
    logic [7:0]               r_in_char;
    logic [LANES:0]           r_row;
    logic                     r_out_valid;
    t_flags                   r_out_flags;
    logic                     advance;

    wsrm_cfg #(
        .LANES (LANES),
        .NW    (NW)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pattern  (pattern),
        .o_used_len (used_len)
    );

    wsrm_step #(
        .LANES (LANES),
        .NW    (NW)
    ) u_step (
        .i_pattern  (pattern),
        .i_used_len (used_len),
        .i_row      (r_row),
        .i_consume  (r_in_type == REQ_CONSUME),
        .i_char     (r_in_char),
        .o_row      (n_row),
        .o_flags    (n_flags)
    );

    // The result register frees up when it is empty or being taken this cycle.
    assign advance   = !r_out_valid || res.ready;
    assign req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
        end else begin
            if (req.ready) begin
                r_in_valid <= req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && advance) begin
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.valid && req.ready) begin
            r_in_type <= req.req_type;
            r_in_char <= req.text_char;
        end
        if (r_in_valid && advance) begin
            r_out_flags <= n_flags;
        end
    end

    assign res.valid          = r_out_valid;
    assign res.whole_match    = r_out_flags.whole_match;
    assign res.still_possible = r_out_flags.still_possible;

`ifndef NO_ASSERTIONS
    a_restart_sets_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in_type == REQ_RESTART) |=> r_row[0])
        else $error("restart word did not mark the empty prefix");

    a_consume_clears_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in_type == REQ_CONSUME) |=> !r_row[0])
        else $error("text byte left the empty prefix alive");

    a_match_is_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flags.whole_match) |-> r_out_flags.still_possible)
        else $error("whole match reported without any live prefix");

    a_stall_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_char) && $stable(r_row)))
        else $error("input word or row changed during a result stall");
`endif

endmodule

`default_nettype wire
